// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top RTL file of the ordered list unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: condition does not hold");

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== hdl/olir_pkg.sv =====
// Types, codes and constants of the ordered list insert and remove unit.
package olir_pkg;

   localparam int DEF_CAPACITY = 16;

   localparam int OP_W     = 3;
   localparam int POS_W    = 5;
   localparam int HANDLE_W = 32;
   localparam int STATUS_W = 3;
   localparam int TOTAL_W  = 5;

   localparam logic [OP_W-1:0] OP_APPEND       = 3'd0;
   localparam logic [OP_W-1:0] OP_PREPEND      = 3'd1;
   localparam logic [OP_W-1:0] OP_INSERT_AT    = 3'd2;
   localparam logic [OP_W-1:0] OP_REMOVE_VALUE = 3'd3;
   localparam logic [OP_W-1:0] OP_REMOVE_AT    = 3'd4;
   localparam logic [OP_W-1:0] OP_CONTAINS     = 3'd5;
   localparam logic [OP_W-1:0] OP_GET          = 3'd6;

   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NULL     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

   typedef struct packed {
      logic [OP_W-1:0]     operation;
      logic [POS_W-1:0]    position;
      logic [HANDLE_W-1:0] handle;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [HANDLE_W-1:0] read_value;
      logic [TOTAL_W-1:0]  entry_total;
   } rsp_type;

   typedef struct packed {
      logic                insert_en;
      logic                remove_at_en;
      logic                remove_val_en;
      logic [HANDLE_W-1:0] handle;
   } cell_cmd_type;

endpackage

// ===== hdl/olir_cell.sv =====
// One list cell: holds one entry, compares it and shifts with its neighbors.
module olir_cell
   import olir_pkg::*;
#(
   parameter int IDX_W = $clog2(DEF_CAPACITY),
   parameter int CNT_W = $clog2(DEF_CAPACITY + 1)
) (
   input  logic                clock,
   input  cell_cmd_type        cmd,
   input  logic [CNT_W-1:0]    cmd_pos,
   input  logic [CNT_W-1:0]    count,
   input  logic [IDX_W-1:0]    cell_index,
   input  logic [HANDLE_W-1:0] left_value,
   input  logic [HANDLE_W-1:0] right_value,
   input  logic                hit_in,
   output logic                hit_out,
   output logic [HANDLE_W-1:0] entry
);

   logic [HANDLE_W-1:0] entry_ff;
   logic [HANDLE_W-1:0] entry_in;
   logic [CNT_W-1:0]    index_ext;
   logic                active;
   logic                match;

   assign index_ext = CNT_W'(cell_index);
   assign active    = index_ext < count;
   assign match     = active && (entry_ff == cmd.handle);
   assign hit_out   = hit_in || match;
   assign entry     = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.insert_en) begin
         if (index_ext == cmd_pos) begin
            entry_in = cmd.handle;
         end else if (index_ext > cmd_pos) begin
            entry_in = left_value;
         end
      end else if (cmd.remove_at_en) begin
         if (index_ext >= cmd_pos) begin
            entry_in = right_value;
         end
      end else if (cmd.remove_val_en) begin
         if (hit_out) begin
            entry_in = right_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== hdl/ordered_list_insert_remove_unit.sv =====
// Ordered list unit: the response is registered, valid in the cycle after request transfer.
// Throughput one request per cycle unless a pending response stalls on rsp_ready;
// every operation completes in one pass because each cell shifts and compares in
// parallel and the first match is found along the chain of cells.
// Synchronous active-high reset empties the list; entry contents stay undefined
// until written, and only entries below the count are ever read.
`include "assert_macros.svh"

module ordered_list_insert_remove_unit
   import olir_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CW    = (CNT_W > POS_W) ? CNT_W : POS_W;

   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   rsp_type             rsp_ff;
   rsp_type             rsp_in;

   logic                req_accept;
   logic [CW-1:0]       pos_ext;
   logic [CW-1:0]       count_ext;
   logic [CW-1:0]       ins_pos;
   logic                is_insert;
   logic                ins_ok;
   logic                null_handle;
   logic                found;
   logic [HANDLE_W-1:0] read_word;
   logic [STATUS_W-1:0] status;
   logic [HANDLE_W-1:0] read_value;
   cell_cmd_type        cmd;
   logic [CNT_W-1:0]    cmd_pos;

   logic [HANDLE_W-1:0] cell_value [CAPACITY];
   logic                cell_hit   [CAPACITY];

   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign req_accept  = req_valid && req_ready;
   assign pos_ext     = CW'(req_data.position);
   assign count_ext   = CW'(count_ff);
   assign null_handle = (req_data.handle == '0);
   assign found       = cell_hit[CAPACITY-1];

   always_comb begin
      case (req_data.operation)
         OP_APPEND:  ins_pos = count_ext;
         OP_PREPEND: ins_pos = '0;
         default:    ins_pos = pos_ext;
      endcase
   end

   assign is_insert = (req_data.operation inside {OP_APPEND, OP_PREPEND, OP_INSERT_AT});
   assign ins_ok    = is_insert && !null_handle && (ins_pos <= count_ext)
                      && (count_ext != CW'(CAPACITY));

   always_comb begin
      read_word = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (CW'(i) == pos_ext) begin
            read_word = read_word | cell_value[i];
         end
      end
   end

   always_comb begin
      status            = ST_OK;
      read_value        = '0;
      count_in          = count_ff;
      cmd.insert_en     = 1'b0;
      cmd.remove_at_en  = 1'b0;
      cmd.remove_val_en = 1'b0;
      cmd.handle        = req_data.handle;
      cmd_pos           = CNT_W'(pos_ext);
      case (req_data.operation)
         OP_APPEND, OP_PREPEND, OP_INSERT_AT: begin
            cmd_pos = CNT_W'(ins_pos);
            if (null_handle) begin
               status = ST_NULL;
            end else if (ins_pos > count_ext) begin
               status = ST_RANGE;
            end else if (count_ext == CW'(CAPACITY)) begin
               status = ST_FULL;
            end else begin
               cmd.insert_en = req_accept;
               if (req_accept) count_in = count_ff + 1'b1;
            end
         end
         OP_REMOVE_VALUE: begin
            if (null_handle) begin
               status = ST_NULL;
            end else if (!found) begin
               status = ST_NOTFOUND;
            end else begin
               cmd.remove_val_en = req_accept;
               if (req_accept) count_in = count_ff - 1'b1;
            end
         end
         OP_REMOVE_AT: begin
            if (pos_ext >= count_ext) begin
               status = ST_RANGE;
            end else begin
               cmd.remove_at_en = req_accept;
               if (req_accept) count_in = count_ff - 1'b1;
            end
         end
         OP_CONTAINS: begin
            if (null_handle) begin
               status = ST_NULL;
            end else if (!found) begin
               status = ST_NOTFOUND;
            end
         end
         OP_GET: begin
            if (pos_ext >= count_ext) begin
               status = ST_RANGE;
            end else begin
               read_value = read_word;
            end
         end
         default: begin
            status = ST_OK;
         end
      endcase
   end

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         logic [HANDLE_W-1:0] left_value;
         logic [HANDLE_W-1:0] right_value;
         logic                hit_in;
         if (g == 0) begin : g_first
            assign left_value = req_data.handle;
            assign hit_in     = 1'b0;
         end else begin : g_inner
            assign left_value = cell_value[g-1];
            assign hit_in     = cell_hit[g-1];
         end
         if (g == CAPACITY - 1) begin : g_last
            assign right_value = cell_value[g];
         end else begin : g_body
            assign right_value = cell_value[g+1];
         end
         olir_cell #(
            .IDX_W (IDX_W),
            .CNT_W (CNT_W)
         ) u_cell (
            .clock       (clock),
            .cmd         (cmd),
            .cmd_pos     (cmd_pos),
            .count       (count_ff),
            .cell_index  (IDX_W'(g)),
            .left_value  (left_value),
            .right_value (right_value),
            .hit_in      (hit_in),
            .hit_out     (cell_hit[g]),
            .entry       (cell_value[g])
         );
      end
   endgenerate

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (req_accept) begin
         rsp_valid_in       = 1'b1;
         rsp_in.status      = status;
         rsp_in.read_value  = read_value;
         rsp_in.entry_total = TOTAL_W'(count_in);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ASSERT_ALWAYS(a_count_bound, clock, reset, CW'(count_ff) <= CW'(CAPACITY))
   `ASSERT_NEXT(a_insert_grows, clock, reset, req_accept && ins_ok, count_ff == CNT_W'($past(count_ff) + 1'b1))
   `ASSERT_NEXT(a_accept_valid, clock, reset, req_accept, rsp_valid_ff)
   `ASSERT_IMPLIES(a_full_no_insert, clock, reset, count_ext == CW'(CAPACITY), !cmd.insert_en)

endmodule
